### hdl/ttd_pkg.sv
package ttd_pkg;

  localparam int MAX_DIM = 1024;
  localparam int DIM_W = 11;
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    FMT_I4     = 3'd0,
    FMT_I8     = 3'd1,
    FMT_IA4    = 3'd2,
    FMT_IA8    = 3'd3,
    FMT_RGB565 = 3'd4,
    FMT_RGB5A3 = 3'd5,
    FMT_RGBA8  = 3'd6,
    FMT_CMPR   = 3'd7
  } fmt_t;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // One classified word, as handed from the front part to the back part.
  typedef struct packed {
    logic [63:0]      word;
    logic [63:0]      ar;
    fmt_t             fmt;
    logic [2:0]       k;
    logic [DIM_W-1:0] ox;
    logic [DIM_W-1:0] oy;
    logic             last_img;
  } job_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [7:0] expand4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] expand3(input logic [2:0] v);
    return {v, v, v[2:1]};
  endfunction

  function automatic logic [31:0] from565(input logic [15:0] v);
    return {expand5(v[15:11]), expand6(v[10:5]), expand5(v[4:0]), 8'hFF};
  endfunction

  function automatic logic [31:0] from5a3(input logic [15:0] v);
    logic [31:0] c;
    if (v[15]) begin
      c = {expand5(v[14:10]), expand5(v[9:5]), expand5(v[4:0]), 8'hFF};
    end else begin
      c = {expand4(v[11:8]), expand4(v[7:4]), expand4(v[3:0]), expand3(v[14:12])};
    end
    return c;
  endfunction

  function automatic logic [7:0] blend38(input logic [7:0] a, input logic [7:0] b);
    logic [10:0] s;
    s = ({3'b0, a} << 1) + {3'b0, a} + ({3'b0, b} << 2) + {3'b0, b};
    return s[10:3];
  endfunction

  function automatic logic [7:0] mid(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

endpackage

### hdl/ttd_front.sv
module ttd_front
  import ttd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [63:0]      in_data_word,
  input  fmt_t             fmt,
  input  logic [DIM_W-1:0] wd,
  input  logic [DIM_W-1:0] ht,
  input  logic             restart,
  input  logic             q_full,
  output logic             q_push,
  output job_t             q_job
);

  logic [DIM_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [2:0]       k_r, k_nxt, k;
  logic [63:0]      ar_r [4];
  logic [3:0]       tw, th, nwords;
  logic             last_word, accept, ar_word;
  logic [DIM_W:0]   ex, ey;

  always_comb begin
    tw = (fmt == FMT_IA8 || fmt == FMT_RGB565 || fmt == FMT_RGB5A3 ||
          fmt == FMT_RGBA8) ? 4'd4 : 4'd8;
    th = (fmt == FMT_I4 || fmt == FMT_CMPR) ? 4'd8 : 4'd4;
    nwords = (fmt == FMT_RGBA8) ? 4'd8 : 4'd4;
    k = ({1'b0, k_r} >= nwords) ? 3'd0 : k_r;
    last_word = ({1'b0, k} == nwords - 4'd1);
    ex = {1'b0, ox_r} + {{(DIM_W-3){1'b0}}, tw};
    ey = {1'b0, oy_r} + {{(DIM_W-3){1'b0}}, th};
  end

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;
  assign ar_word = (fmt == FMT_RGBA8) && !k[2];
  // Alpha-red words of an RGBA8 tile give no texels and stay out of the queue.
  assign q_push = accept && !ar_word;

  always_comb begin
    q_job.word = in_data_word;
    q_job.ar = ar_r[k[1:0]];
    q_job.fmt = fmt;
    q_job.k = k;
    q_job.ox = ox_r;
    q_job.oy = oy_r;
    q_job.last_img = last_word && (ex >= {1'b0, wd}) && (ey >= {1'b0, ht});
  end

  always_comb begin
    ox_nxt = ox_r;
    oy_nxt = oy_r;
    k_nxt = k_r;
    if (restart) begin
      ox_nxt = '0;
      oy_nxt = '0;
      k_nxt = '0;
    end else if (accept) begin
      if (last_word) begin
        k_nxt = '0;
        if (ex >= {1'b0, wd}) begin
          ox_nxt = '0;
          oy_nxt = (ey >= {1'b0, ht}) ? '0 : ey[DIM_W-1:0];
        end else begin
          ox_nxt = ex[DIM_W-1:0];
        end
      end else begin
        k_nxt = k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0;
      oy_r <= '0;
      k_r <= '0;
    end else begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      k_r <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ar_word) begin
      ar_r[k[1:0]] <= in_data_word;
    end
  end

endmodule

### hdl/ttd_queue.sv
module ttd_queue
  import ttd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t head
);

  job_t         mem_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic [$clog2(QDEPTH):0]   cnt_r;

  assign full = (cnt_r == QDEPTH[$clog2(QDEPTH):0]);
  assign not_empty = (cnt_r != '0);
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

endmodule

### hdl/ttd_back.sv
module ttd_back
  import ttd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  job_t             q_job,
  output logic             q_pop,
  input  logic [DIM_W-1:0] wd,
  input  logic [DIM_W-1:0] ht,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_texel_color,
  output logic [DIM_W-1:0] out_texel_x,
  output logic [DIM_W-1:0] out_texel_y,
  output logic             out_inside_res,
  output logic             out_last_of_item,
  output logic             out_last_of_image
);

  logic [3:0]  i_r;
  logic [3:0]  n;
  logic [31:0] col;
  logic [2:0]  dx, dy;
  logic [7:0]  b;
  logic [15:0] h, c0, c1;
  logic [31:0] p0, p1;
  logic [1:0]  sel;
  logic [7:0]  ar_a, ar_r8;
  logic [7:0]  gb_g, gb_b;
  logic        load, last;
  logic [DIM_W-1:0] x, y;

  always_comb begin
    case (q_job.fmt)
      FMT_I4, FMT_CMPR: n = 4'd15;
      FMT_I8, FMT_IA4:  n = 4'd7;
      default:          n = 4'd3;
    endcase
  end

  always_comb begin
    b = q_job.word[63 - 8*i_r[2:0] -: 8];
    h = q_job.word[63 - 16*i_r[1:0] -: 16];
    ar_a = q_job.ar[63 - 16*i_r[1:0] -: 8];
    ar_r8 = q_job.ar[55 - 16*i_r[1:0] -: 8];
    gb_g = h[15:8];
    gb_b = h[7:0];
    c0 = q_job.word[63:48];
    c1 = q_job.word[47:32];
    p0 = from565(c0);
    p1 = from565(c1);
    sel = q_job.word[31 - 2*i_r -: 2];
    col = '0;
    dx = '0;
    dy = '0;
    case (q_job.fmt)
      FMT_I4: begin
        b = q_job.word[63 - 8*i_r[3:1] -: 8];
        col = i_r[0] ? {4{expand4(b[3:0])}} : {4{expand4(b[7:4])}};
        dx = {i_r[2:1], i_r[0]};
        dy = {q_job.k[1:0], i_r[3]};
      end
      FMT_I8: begin
        col = {4{b}};
        dx = i_r[2:0];
        dy = q_job.k;
      end
      FMT_IA4: begin
        col = {{3{expand4(b[3:0])}}, expand4(b[7:4])};
        dx = i_r[2:0];
        dy = q_job.k;
      end
      FMT_IA8: begin
        col = {{3{h[7:0]}}, h[15:8]};
        dx = {1'b0, i_r[1:0]};
        dy = q_job.k;
      end
      FMT_RGB565: begin
        col = from565(h);
        dx = {1'b0, i_r[1:0]};
        dy = q_job.k;
      end
      FMT_RGB5A3: begin
        col = from5a3(h);
        dx = {1'b0, i_r[1:0]};
        dy = q_job.k;
      end
      FMT_RGBA8: begin
        col = {ar_r8, gb_g, gb_b, ar_a};
        dx = {1'b0, i_r[1:0]};
        dy = {1'b0, q_job.k[1:0]};
      end
      FMT_CMPR: begin
        case (sel)
          2'd0: col = p0;
          2'd1: col = p1;
          2'd2: col = (c0 > c1) ?
            {blend38(p1[31:24], p0[31:24]), blend38(p1[23:16], p0[23:16]),
             blend38(p1[15:8], p0[15:8]), 8'hFF} :
            {mid(p0[31:24], p1[31:24]), mid(p0[23:16], p1[23:16]),
             mid(p0[15:8], p1[15:8]), 8'hFF};
          default: col = (c0 > c1) ?
            {blend38(p0[31:24], p1[31:24]), blend38(p0[23:16], p1[23:16]),
             blend38(p0[15:8], p1[15:8]), 8'hFF} :
            {mid(p0[31:24], p1[31:24]), mid(p0[23:16], p1[23:16]),
             mid(p0[15:8], p1[15:8]), 8'h00};
        endcase
        dx = {q_job.k[0], i_r[1:0]};
        dy = {q_job.k[1], i_r[3:2]};
      end
      default: col = '0;
    endcase
    x = q_job.ox + {{(DIM_W-3){1'b0}}, dx};
    y = q_job.oy + {{(DIM_W-3){1'b0}}, dy};
    last = (i_r == n);
  end

  // The output register takes a texel whenever it is empty or being drained.
  assign load = q_valid && (!out_valid || !out_stall);
  assign q_pop = load && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        i_r <= last ? 4'd0 : i_r + 4'd1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_texel_color <= col;
      out_texel_x <= x;
      out_texel_y <= y;
      out_inside_res <= (x < wd) && (y < ht);
      out_last_of_item <= last;
      out_last_of_image <= last && q_job.last_img;
    end
  end

endmodule

### hdl/tiled_texture_decoder.sv
// Tiled texture decoder. Each request on the input channel is one big-endian
// 64-bit texture word; the block answers with 0, 4, 8 or 16 RGBA8 texels on
// the output channel, one per cycle while the output is not stalled, each with
// its padded coordinates, an inside flag, and end-of-word and end-of-image
// markers. The output channel sets the pace: a word yields 16 texels for I4
// and CMPR, 8 for I8 and IA4, 4 for the 16-bit formats and RGBA8 green-blue
// words, while RGBA8 alpha-red words are absorbed and yield none. A front
// part tracks the tile walk and stores alpha-red words, a two-entry queue
// holds classified words, and a back part expands them texel by texel into
// an output register. Registers sit at byte addresses 0 (format), 4 (width)
// and 8 (height); width and height are clamped to 1..1024, and a write to any
// of them restarts the walk at the first tile. Write registers only while idle.
module tiled_texture_decoder
  import ttd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [63:0]      in_data_word,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_texel_color,
  output logic [DIM_W-1:0] out_texel_x,
  output logic [DIM_W-1:0] out_texel_y,
  output logic             out_inside_res,
  output logic             out_last_of_item,
  output logic             out_last_of_image,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [3:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  fmt_t             fmt_r;
  logic [DIM_W-1:0] w_r, h_r, wd, ht;
  logic             wr, restart;
  logic             q_full, q_push, q_pop, q_valid;
  job_t             push_job, head_job;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  // A write to any of the three registers restarts the tile walk; a write to
  // an unused address is ignored.
  assign restart = wr && (cfg_paddr[3:2] == REG_FORMAT || cfg_paddr[3:2] == REG_WIDTH ||
                          cfg_paddr[3:2] == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_I4;
      w_r <= 11'd1;
      h_r <= 11'd1;
    end else if (wr) begin
      case (cfg_paddr[3:2])
        REG_FORMAT: fmt_r <= fmt_t'(cfg_pwdata[2:0]);
        REG_WIDTH:  w_r <= cfg_pwdata[DIM_W-1:0];
        REG_HEIGHT: h_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_FORMAT: cfg_prdata = {29'd0, fmt_r};
      REG_WIDTH:  cfg_prdata = {21'd0, w_r};
      REG_HEIGHT: cfg_prdata = {21'd0, h_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // Dimensions as used by the walk: zero acts as one, and anything above the
  // largest supported size acts as that size.
  always_comb begin
    wd = (w_r == '0) ? 11'd1 : (w_r > 11'(MAX_DIM)) ? 11'(MAX_DIM) : w_r;
    ht = (h_r == '0) ? 11'd1 : (h_r > 11'(MAX_DIM)) ? 11'(MAX_DIM) : h_r;
  end

  ttd_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_word,
    .fmt(fmt_r), .wd, .ht, .restart,
    .q_full, .q_push, .q_job(push_job)
  );

  ttd_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_job, .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .head(head_job)
  );

  ttd_back u_back (
    .clk, .rst_n, .q_valid, .q_job(head_job), .q_pop, .wd, .ht,
    .out_valid, .out_stall, .out_texel_color, .out_texel_x, .out_texel_y,
    .out_inside_res, .out_last_of_item, .out_last_of_image
  );

endmodule

### hdl/ttd_checker.sv
module ttd_checker
  import ttd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [31:0]      out_texel_color,
  input logic [DIM_W-1:0] out_texel_x,
  input logic             out_last_of_item,
  input logic             out_last_of_image
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_texel_color))
    else $error("stalled texel changed");

  a_img_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_image |-> out_last_of_item)
    else $error("image end without word end");

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_texel_x < 11'(MAX_DIM + 8))
    else $error("texel column out of range");

  a_stall_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_stall))
    else $error("input stall unknown");

endmodule

bind tiled_texture_decoder ttd_checker u_ttd_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_texel_color, .out_texel_x, .out_last_of_item, .out_last_of_image
);

### verif/tiled_texture_decoder_tb.sv
module tiled_texture_decoder_tb;
  import ttd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected texel, field by field as the output channel carries it.
  typedef struct {
    logic [31:0]      color;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic             in_img;
    logic             last_word;
    logic             last_img;
  } texel_t;

  // Scoreboard: a model of the tile walk plus the queue of texels still owed.
  class texel_scoreboard;
    fmt_t        fmt = FMT_I4;
    int unsigned width_reg = 1, height_reg = 1;
    int unsigned org_x, org_y, word_idx;
    logic [63:0] ar_words[4];
    texel_t      owed[$];
    int          errors;
    int          texels_seen;

    function void restart_walk();
      org_x = 0;
      org_y = 0;
      word_idx = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_FORMAT: fmt = fmt_t'(v[2:0]);
        REG_WIDTH:  width_reg = v[10:0];
        REG_HEIGHT: height_reg = v[10:0];
        default: ;
      endcase
      restart_walk();
    endfunction

    function int unsigned clamp_dim(int unsigned v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function logic [7:0] x5(logic [4:0] v);
      return {v, v[4:2]};
    endfunction

    function logic [7:0] x4(logic [3:0] v);
      return {v, v};
    endfunction

    function logic [31:0] rgb565(logic [15:0] v);
      return {x5(v[15:11]), v[10:5], v[10:9], x5(v[4:0]), 8'hFF};
    endfunction

    function logic [31:0] rgb5a3(logic [15:0] v);
      if (v[15]) return {x5(v[14:10]), x5(v[9:5]), x5(v[4:0]), 8'hFF};
      return {x4(v[11:8]), x4(v[7:4]), x4(v[3:0]), v[14:12], v[14:12], v[14:13]};
    endfunction

    function logic [7:0] mix38(logic [7:0] a, logic [7:0] b);
      int unsigned s;
      s = a * 3 + b * 5;
      return 8'(s >> 3);
    endfunction

    // Works out the texels that one accepted word owes and advances the walk.
    function void note_word(logic [63:0] w);
      int unsigned wd, ht, tw, th, nwords, k, n, ax, ay;
      logic [31:0] col[16];
      int unsigned dx[16], dy[16];
      logic [7:0] b, v;
      logic [15:0] h, c0, c1;
      logic [31:0] pal[4];
      logic end_word, end_img;
      texel_t t;
      wd = clamp_dim(width_reg);
      ht = clamp_dim(height_reg);
      tw = (fmt inside {FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_RGBA8}) ? 4 : 8;
      th = (fmt == FMT_I4 || fmt == FMT_CMPR) ? 8 : 4;
      nwords = (fmt == FMT_RGBA8) ? 8 : 4;
      k = word_idx;
      if (k >= nwords) k = 0;
      end_word = (k == nwords - 1);
      end_img = end_word && org_x + tw >= wd && org_y + th >= ht;
      n = 0;
      case (fmt)
        FMT_I4: begin
          for (int i = 0; i < 8; i++) begin
            b = w[63 - 8 * i -: 8];
            col[n] = {4{x4(b[7:4])}}; dx[n] = (i % 4) * 2; dy[n] = k * 2 + i / 4; n++;
            col[n] = {4{x4(b[3:0])}}; dx[n] = (i % 4) * 2 + 1; dy[n] = k * 2 + i / 4; n++;
          end
        end
        FMT_I8, FMT_IA4: begin
          for (int i = 0; i < 8; i++) begin
            b = w[63 - 8 * i -: 8];
            v = x4(b[3:0]);
            col[n] = (fmt == FMT_I8) ? {4{b}} : {v, v, v, x4(b[7:4])};
            dx[n] = i; dy[n] = k; n++;
          end
        end
        FMT_IA8, FMT_RGB565, FMT_RGB5A3: begin
          for (int i = 0; i < 4; i++) begin
            h = w[63 - 16 * i -: 16];
            if (fmt == FMT_IA8) col[n] = {h[7:0], h[7:0], h[7:0], h[15:8]};
            else if (fmt == FMT_RGB565) col[n] = rgb565(h);
            else col[n] = rgb5a3(h);
            dx[n] = i; dy[n] = k; n++;
          end
        end
        FMT_RGBA8: begin
          if (k < 4) begin
            ar_words[k] = w;
          end else begin
            for (int i = 0; i < 4; i++) begin
              col[n] = {ar_words[k - 4][55 - 16 * i -: 8], w[63 - 16 * i -: 16],
                        ar_words[k - 4][63 - 16 * i -: 8]};
              dx[n] = i; dy[n] = k - 4; n++;
            end
          end
        end
        default: begin
          c0 = w[63:48];
          c1 = w[47:32];
          pal[0] = rgb565(c0);
          pal[1] = rgb565(c1);
          if (c0 > c1) begin
            pal[2] = {mix38(pal[1][31:24], pal[0][31:24]), mix38(pal[1][23:16], pal[0][23:16]),
                      mix38(pal[1][15:8], pal[0][15:8]), 8'hFF};
            pal[3] = {mix38(pal[0][31:24], pal[1][31:24]), mix38(pal[0][23:16], pal[1][23:16]),
                      mix38(pal[0][15:8], pal[1][15:8]), 8'hFF};
          end else begin
            pal[2][31:24] = 8'((9'(pal[0][31:24]) + pal[1][31:24]) >> 1);
            pal[2][23:16] = 8'((9'(pal[0][23:16]) + pal[1][23:16]) >> 1);
            pal[2][15:8]  = 8'((9'(pal[0][15:8]) + pal[1][15:8]) >> 1);
            pal[2][7:0]   = 8'hFF;
            pal[3] = {pal[2][31:8], 8'h00};
          end
          for (int i = 0; i < 16; i++) begin
            col[n] = pal[w[31 - 2 * i -: 2]];
            dx[n] = (k % 2) * 4 + i % 4;
            dy[n] = (k / 2) * 4 + i / 4;
            n++;
          end
        end
      endcase
      for (int i = 0; i < n; i++) begin
        ax = org_x + dx[i];
        ay = org_y + dy[i];
        t.color = col[i];
        t.x = ax[DIM_W-1:0];
        t.y = ay[DIM_W-1:0];
        t.in_img = (ax < wd && ay < ht);
        t.last_word = (i == n - 1);
        t.last_img = (i == n - 1) && end_img;
        owed.push_back(t);
      end
      if (end_word) begin
        word_idx = 0;
        org_x += tw;
        if (org_x >= wd) begin
          org_x = 0;
          org_y += th;
          if (org_y >= ht) org_y = 0;
        end
      end else begin
        word_idx = k + 1;
      end
    endfunction

    function void check_texel(texel_t got);
      texel_t e;
      texels_seen++;
      if (owed.size() == 0) begin
        $error("texel at (%0d,%0d) arrived with none outstanding", got.x, got.y);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (got.color !== e.color) begin
        $error("texel_color expected %h actual %h", e.color, got.color); errors++;
      end
      if (got.x !== e.x) begin
        $error("texel_x expected %0d actual %0d", e.x, got.x); errors++;
      end
      if (got.y !== e.y) begin
        $error("texel_y expected %0d actual %0d", e.y, got.y); errors++;
      end
      if (got.in_img !== e.in_img) begin
        $error("inside_res expected %b actual %b", e.in_img, got.in_img); errors++;
      end
      if (got.last_word !== e.last_word) begin
        $error("last_of_item expected %b actual %b", e.last_word, got.last_word); errors++;
      end
      if (got.last_img !== e.last_img) begin
        $error("last_of_image expected %b actual %b", e.last_img, got.last_img); errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [63:0]      in_data_word = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [31:0]      out_texel_color;
  logic [DIM_W-1:0] out_texel_x;
  logic [DIM_W-1:0] out_texel_y;
  logic             out_inside_res;
  logic             out_last_of_item;
  logic             out_last_of_image;
  logic             cfg_psel = 1'b0;
  logic             cfg_penable = 1'b0;
  logic             cfg_pwrite = 1'b0;
  logic [3:0]       cfg_paddr = '0;
  logic [31:0]      cfg_pwdata = '0;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  tiled_texture_decoder dut (.*);

  always #1 clk = ~clk;

  texel_scoreboard sb = new();

  // Idle rates out of a hundred for each side; the hold flag lets the
  // pressure phase freeze the receiver for a long stretch.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          recv_hold = 1'b0;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          timed_out = 1'b0;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  // Result side: check every accepted texel, then choose the next stall.
  always @(posedge clk) begin
    texel_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.color = out_texel_color;
      got.x = out_texel_x;
      got.y = out_texel_y;
      got.in_img = out_inside_res;
      got.last_word = out_last_of_item;
      got.last_img = out_last_of_image;
      sb.check_texel(got);
    end
    out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: any cycle with neither channel moving and no register access counts toward the limit.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d texels outstanding", sb.owed.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // APB write, setup phase then access phase. The model restarts its walk at the same edge.
  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.write_reg(idx, v);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Let every owed texel drain, plus a margin for a word still in flight.
  task automatic drain();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Task go_idle is declared below; the sender drops valid before any write.
  task automatic configure(fmt_t f, int unsigned w, int unsigned h);
    go_idle();
    drain();
    reg_write(REG_FORMAT, 32'(f));
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  // Offers one word and holds it until accepted. The random idle gap comes
  // first, so valid stays high across back-to-back requests.
  task automatic send_word(logic [63:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Random CMPR words split between the two palette modes so both show up.
  function automatic logic [63:0] rand_cmpr();
    logic [63:0] w;
    w = rand_word();
    if ($urandom_range(1)) w[47:32] = w[63:48];
    return w;
  endfunction

  // A random phase sends runs of words on images of a random, mostly small size, so the walk
  // reaches image wrap-around and the end-of-image flag regularly.
  task automatic random_phase(int unsigned count);
    fmt_t f;
    int unsigned w, h;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      f = fmt_t'($urandom_range(7));
      w = ($urandom_range(9) == 0) ? $urandom_range(1023, 1) : $urandom_range(20, 1);
      h = $urandom_range(12, 1);
      if ($urandom_range(15) == 0) w = 0;
      if ($urandom_range(15) == 0) h = 2047 - $urandom_range(900);
      if (w > MAX_DIM && h > 16) h = $urandom_range(8, 1);
      go_idle();
      configure(f, w, h);
      repeat ($urandom_range(24, 4)) begin
        send_word((f == FMT_CMPR) ? rand_cmpr() : rand_word());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults first (I4, 1x1), then all-zero and all-one words
    // through every format, a wide image clamped to 1024 and a zero height, and
    // the two CMPR palette modes and both RGB5A3 encodings.
    send_word(64'h0123_4567_89AB_CDEF);
    for (int f = 0; f < 8; f++) begin
      configure(fmt_t'(f), 5, 3);
      send_word('0);
      send_word('1);
      if (fmt_t'(f) == FMT_RGBA8) begin
        for (int i = 0; i < 6; i++) send_word(rand_word());
      end
    end
    configure(FMT_CMPR, 2047, 0);
    send_word(64'hF800_001F_E4E4_E4E4);
    send_word(64'h001F_F800_1B1B_1B1B);
    send_word(64'h7BEF_7BEF_FFFF_0000);
    configure(FMT_RGB5A3, 1, 1);
    send_word(64'h8000_7FFF_FFFF_0000);
    go_idle();

    // Pressure: stall the receiver for a long stretch while the sender keeps
    // offering I4 words, so the internal queue fills and the input stalls.
    configure(FMT_I4, 16, 16);
    recv_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 10; i++) send_word(rand_word());
    join
    go_idle();
    drain();

    send_idle_pct = 10;
    recv_idle_pct = 83;
    random_phase(55);
    send_idle_pct = 83;
    recv_idle_pct = 10;
    random_phase(55);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(55);
    go_idle();
    drain();
    repeat (50) @(posedge clk);

    $display("Sent %0d words across all eight formats and many image sizes;", words_sent);
    $display("checked %0d texels under stalls on either side.", sb.texels_seen);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
hdl/ttd_pkg.sv
hdl/ttd_front.sv
hdl/ttd_queue.sv
hdl/ttd_back.sv
hdl/tiled_texture_decoder.sv
hdl/ttd_checker.sv
verif/tiled_texture_decoder_tb.sv
